>>> src/assert_macros.svh
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset
`define ADP_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Plain condition checked on every rising edge outside reset
`define ADP_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

>>> src/adp_pkg.sv
// ----------------------------------------------------------------------------
// adp_pkg
// Shared types and constants for the array duplicate detector.
// ----------------------------------------------------------------------------
`default_nettype none

package adp_pkg;

  localparam int unsigned DATA_W = 64;

  typedef struct packed {
    logic insert;
    logic clear;
  } store_req_t;

  typedef struct packed {
    logic hit;
    logic full;
  } store_stat_t;

endpackage

`default_nettype wire

>>> src/adp_store.sv
// ----------------------------------------------------------------------------
// adp_store
// Bounded set of distinct values with parallel lookup, append and clear.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module adp_store
  import adp_pkg::*;
#(
  parameter int unsigned MAX_DISTINCT = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [DATA_W-1:0] value,
  input  wire store_req_t        req,
  output store_stat_t            stat
);

  localparam int unsigned OCC_W = $clog2(MAX_DISTINCT + 1);
  localparam int unsigned IDX_W = $clog2(MAX_DISTINCT);

  logic [DATA_W-1:0]       seen_r [MAX_DISTINCT];
  logic [OCC_W-1:0]        occ_r;
  logic [OCC_W-1:0]        occ_nxt;
  logic [MAX_DISTINCT-1:0] hit_vec;

  for (genvar k = 0; k < MAX_DISTINCT; k++) begin : g_cmp
    assign hit_vec[k] = (occ_r > OCC_W'(k)) && (seen_r[k] == value);
  end

  always_comb begin
    stat.hit  = |hit_vec;
    stat.full = (occ_r == OCC_W'(MAX_DISTINCT));
    occ_nxt   = occ_r;
    if (req.clear) begin
      occ_nxt = '0;
    end else if (req.insert) begin
      occ_nxt = occ_r + OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.insert && !stat.full) begin
      seen_r[occ_r[IDX_W-1:0]] <= value;
    end
  end

  `ADP_ASSERT_ALWAYS(a_occ_bound, clk, rst_n, occ_r <= OCC_W'(MAX_DISTINCT),
    "occupancy beyond capacity")
  `ADP_ASSERT_ALWAYS(a_hit_unique, clk, rst_n, $onehot0(hit_vec),
    "value stored more than once")
  `ADP_ASSERT_IMP(a_no_insert_full, clk, rst_n, req.insert, !stat.full && !stat.hit,
    "insert into full store or of a stored value")

endmodule

`default_nettype wire

>>> src/array_duplicate_detector_core.sv
// ----------------------------------------------------------------------------
// array_duplicate_detector_core
// Flags repeated values or repeated nulls within each array of a stream, and overflow.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in_      input      in_valid / in_stall   element_value, element_is_null,
//                                            last_of_array, no_element
//  out_     output     out_valid / out_stall has_duplicate, capacity_overflow
//
//  One item per cycle while not stalled; input register, then result register.
//  Rate set by the combinational parallel compare against the value store.
//  Synchronous active-low reset clears occupancy, flags and valids.
//  A stalled result holds back only an item that closes an array.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module array_duplicate_detector_core
  import adp_pkg::*;
#(
  parameter int unsigned MAX_DISTINCT = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [DATA_W-1:0] in_element_value,
  input  wire logic                     in_element_is_null,
  input  wire logic                     in_last_of_array,
  input  wire logic                     in_no_element,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          out_has_duplicate,
  output logic                          out_capacity_overflow
);

  logic                     s1_valid_r;
  logic signed [DATA_W-1:0] s1_value_r;
  logic                     s1_null_r;
  logic                     s1_last_r;
  logic                     s1_none_r;

  logic null_seen_r, null_seen_nxt;
  logic dup_r, dup_nxt;
  logic ovf_r, ovf_nxt;

  logic out_valid_r;
  logic out_dup_r;
  logic out_ovf_r;

  logic        adv;
  logic        take;
  store_req_t  req;
  store_stat_t stat;

  adp_store #(
    .MAX_DISTINCT(MAX_DISTINCT)
  ) u_store (
    .clk  (clk),
    .rst_n(rst_n),
    .value(s1_value_r),
    .req  (req),
    .stat (stat)
  );

  always_comb begin
    adv           = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
    take          = adv && !s1_none_r && !dup_r;
    null_seen_nxt = null_seen_r;
    dup_nxt       = dup_r;
    ovf_nxt       = ovf_r;
    req.insert    = 1'b0;
    req.clear     = adv && s1_last_r;
    if (take) begin
      if (s1_null_r) begin
        if (null_seen_r) begin
          dup_nxt = 1'b1;
        end else begin
          null_seen_nxt = 1'b1;
        end
      end else if (stat.hit) begin
        dup_nxt = 1'b1;
      end else if (stat.full) begin
        ovf_nxt = 1'b1;
      end else begin
        req.insert = 1'b1;
      end
    end
  end

  assign in_stall              = s1_valid_r && !adv;
  assign out_valid             = out_valid_r;
  assign out_has_duplicate     = out_dup_r;
  assign out_capacity_overflow = out_ovf_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_value_r <= in_element_value;
      s1_null_r  <= in_element_is_null;
      s1_last_r  <= in_last_of_array;
      s1_none_r  <= in_no_element;
    end
  end

  // per-array flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      null_seen_r <= 1'b0;
      dup_r       <= 1'b0;
      ovf_r       <= 1'b0;
    end else if (req.clear) begin
      null_seen_r <= 1'b0;
      dup_r       <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      null_seen_r <= null_seen_nxt;
      dup_r       <= dup_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (req.clear) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.clear) begin
      out_dup_r <= dup_nxt;
      out_ovf_r <= ovf_nxt;
    end
  end

  `ADP_ASSERT_IMP(a_result_from_close, clk, rst_n, $rose(out_valid_r),
    $past(req.clear), "result without closing item")
  `ADP_ASSERT_IMP(a_flags_cleared, clk, rst_n, $past(req.clear) && rst_n && $past(rst_n),
    !dup_r && !ovf_r && !null_seen_r, "flags not cleared after close")
  `ADP_ASSERT_IMP(a_dup_sticky, clk, rst_n, dup_r && !req.clear, dup_nxt,
    "duplicate flag dropped within array")

endmodule

`default_nettype wire
